// ===== rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the Markov substitution sampler.
// ----------------------------------------------------------------------------
package mss_pkg;

   localparam int NUM_STATES_DEF = 20;

   // request opcodes
   localparam logic [2:0] OP_LOAD_EVAL = 3'd0;
   localparam logic [2:0] OP_LOAD_EVEC = 3'd1;
   localparam logic [2:0] OP_PROB      = 3'd2;
   localparam logic [2:0] OP_SAMPLE    = 3'd3;
   localparam logic [2:0] OP_EQUIL     = 3'd4;

   localparam int MUL_W = 36;

   localparam logic signed [MUL_W-1:0] LOG2E_Q28 = 36'sd387270501;
   localparam logic signed [71:0]      X_LO      = -72'sd8589934592;
   localparam logic signed [71:0]      X_HI      = 72'sd1073741824;
   localparam logic [63:0]             EXP_MAX   = 64'h0000_0000_7FFF_FFFF;
   localparam logic signed [39:0]      PROB_MAX  = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0]      PROB_MIN  = 40'sh80_0000_0000;
   localparam logic [2:0]              HORNER_LAST = 3'd6;
   localparam logic [5:0]              DIV_STEPS = 6'd38;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EXP_RD,
      S_EXP_LT,
      S_EXP_X,
      S_EXP_Y,
      S_EXP_MUL,
      S_EXP_ADD,
      S_EXP_SH,
      S_TRM_RD,
      S_TRM_M1,
      S_TRM_M2,
      S_TRM_ACC,
      S_FRQ_RD,
      S_FRQ,
      S_DIV,
      S_POST,
      S_EQ_RD,
      S_EQ,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [4:0]         row_index;
      logic [4:0]         col_index;
      logic signed [31:0] table_value;
      logic [31:0]        elapsed_time;
      logic [31:0]        uniform_draw;
   } req_type;

   typedef struct packed {
      logic [4:0]         chosen_state;
      logic signed [39:0] probability;
      logic               fell_through;
      logic               saturated;
   } rsp_type;

   // Horner coefficients of 2^f in Q.28, last one is the leading 1.0
   function automatic logic [29:0] pow2_coef(input logic [2:0] idx);
      logic [29:0] c;
      case (idx)
         3'd0:    c = 30'd41349;
         3'd1:    c = 30'd357920;
         3'd2:    c = 30'd2581847;
         3'd3:    c = 30'd14899271;
         3'd4:    c = 30'd64485312;
         3'd5:    c = 30'd186065280;
         default: c = 30'd268435456;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/markov_substitution_sampler.sv =====
// ----------------------------------------------------------------------------
// markov_substitution_sampler
// Eigen-decomposition based transition probability and sampling engine.
// ----------------------------------------------------------------------------
// A load is written when accepted. A probability request computes N exponentials on the
// shared 36x36 multiplier, then N terms and a 39-step radix-2 divide (skipped for a zero
// frequency or an overflowing quotient). A substitution sample computes the exponentials
// once, then a probability per target walked; an equilibrium sample walks eigenvector row 0.
// One request in flight; the next is taken the cycle after the result is registered.
// Reset clears control only; the eigen tables are undefined until loaded.
module markov_substitution_sampler #(
   parameter int NUM_STATES = mss_pkg::NUM_STATES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mss_pkg::rsp_type rsp_data
);
   import mss_pkg::*;

   localparam int IDX_W  = $clog2(NUM_STATES);
   localparam int VEC_N  = NUM_STATES * NUM_STATES;
   localparam int VEC_AW = $clog2(VEC_N);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_STATES - 1);

   // storage: eigenvalues, eigenvectors, per-request exponentials
   logic [31:0] eval_mem [NUM_STATES];
   logic [31:0] evec_mem [VEC_N];
   logic [31:0] exp_mem  [NUM_STATES];

   logic              eval_we, vec_we, exp_we;
   logic [IDX_W-1:0]  eval_waddr, eval_raddr, exp_waddr, exp_raddr;
   logic [VEC_AW-1:0] vec_waddr, vec_raddr0, vec_raddr1;
   logic [31:0]       exp_wdata;
   logic [31:0]       eval_rd_ff, vec_rd0_ff, vec_rd1_ff, exp_rd_ff;

   always_ff @(posedge clock) begin
      if (eval_we) begin
         eval_mem[eval_waddr] <= req_data.table_value;
      end
      eval_rd_ff <= eval_mem[eval_raddr];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         evec_mem[vec_waddr] <= req_data.table_value;
      end
      vec_rd0_ff <= evec_mem[vec_raddr0];
      vec_rd1_ff <= evec_mem[vec_raddr1];
   end

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_waddr] <= exp_wdata;
      end
      exp_rd_ff <= exp_mem[exp_raddr];
   end

   // shared multiplier, product always registered
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [71:0]      prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [IDX_W-1:0]   from_ff, from_in, to_ff, to_in, j_ff, j_in, k_ff, k_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [VEC_AW-1:0]  base_ff, base_in;
   logic [31:0]        time_ff, time_in, u_ff, u_in;
   logic signed [7:0]  n_ff, n_in;
   logic [27:0]        f_ff, f_in;
   logic [29:0]        acc_ff, acc_in;
   logic signed [47:0] sum_ff, sum_in;
   logic [31:0]        freq_ff, freq_in;
   logic               neg_ff, neg_in;
   logic [32:0]        r_ff, r_in;
   logic [38:0]        nb_ff, nb_in, q_ff, q_in;
   logic signed [39:0] pr_ff, pr_in, run_ff, run_in;
   logic [37:0]        cum_ff, cum_in;
   logic               sat_ff, sat_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // request decode helpers
   logic              row_ok, col_ok;
   logic [IDX_W-1:0]  row_cl, col_cl;

   assign row_ok = (int'(req_data.row_index) < NUM_STATES);
   assign col_ok = (int'(req_data.col_index) < NUM_STATES);
   assign row_cl = row_ok ? IDX_W'(req_data.row_index) : LAST;
   assign col_cl = col_ok ? IDX_W'(req_data.col_index) : LAST;

   // datapath temporaries
   logic signed [71:0] xs;
   logic signed [MUL_W-1:0] x_cl;
   logic [63:0]        r64;
   logic [5:0]         nsh;
   logic [31:0]        fq;
   logic [47:0]        mg;
   logic [32:0]        rt;
   logic               ge;
   logic signed [40:0] s41;
   logic signed [39:0] run_new;
   logic [37:0]        cum_new;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; from_in = from_ff; to_in = to_ff; j_in = j_ff; k_in = k_ff;
      cnt_in = cnt_ff; base_in = base_ff; time_in = time_ff; u_in = u_ff;
      n_in = n_ff; f_in = f_ff; acc_in = acc_ff; sum_in = sum_ff;
      freq_in = freq_ff; neg_in = neg_ff; r_in = r_ff;
      nb_in = nb_ff; q_in = q_ff; pr_in = pr_ff; run_in = run_ff;
      cum_in = cum_ff; sat_in = sat_ff; res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      mul_a = '0;
      mul_b = '0;
      eval_we = 1'b0; vec_we = 1'b0; exp_we = 1'b0;
      eval_waddr = row_cl;
      eval_raddr = j_ff;
      vec_waddr  = VEC_AW'(int'(row_cl) * NUM_STATES + int'(col_cl));
      vec_raddr0 = VEC_AW'(int'(base_ff) + int'(to_ff));
      vec_raddr1 = VEC_AW'(int'(base_ff) + int'(from_ff));
      exp_waddr  = j_ff;
      exp_raddr  = k_ff;

      xs   = prod_ff >>> 16;
      x_cl = (xs < X_LO) ? MUL_W'(X_LO) : ((xs > X_HI) ? MUL_W'(X_HI) : MUL_W'(xs));
      nsh  = 6'(-n_ff);
      r64  = (n_ff >= 0) ? (64'(acc_ff) << n_ff[2:0]) : (64'(acc_ff) >> nsh);
      exp_wdata = (r64 > EXP_MAX) ? EXP_MAX[31:0] : r64[31:0];

      fq = vec_rd0_ff[31] ? (~vec_rd0_ff + 32'd1) : vec_rd0_ff;
      mg = sum_ff[47] ? 48'(-sum_ff) : 48'(sum_ff);
      rt = {r_ff[31:0], nb_ff[38]};
      ge = (rt >= {1'b0, freq_ff});

      s41 = {run_ff[39], run_ff} + {pr_ff[39], pr_ff};
      if (s41[40] != s41[39]) begin
         run_new = s41[40] ? PROB_MIN : PROB_MAX;
      end else begin
         run_new = s41[39:0];
      end
      cum_new = cum_ff + 38'(fq);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.opcode;
               from_in = row_cl;
               to_in   = (req_data.opcode == OP_PROB) ? col_cl : '0;
               time_in = req_data.elapsed_time;
               u_in    = req_data.uniform_draw;
               j_in    = '0;
               sat_in  = 1'b0;
               run_in  = '0;
               cum_in  = '0;
               case (req_data.opcode)
                  OP_LOAD_EVAL: eval_we = row_ok;
                  OP_LOAD_EVEC: vec_we  = row_ok && col_ok;
                  OP_PROB, OP_SAMPLE: state_in = S_EXP_RD;
                  OP_EQUIL: state_in = S_EQ_RD;
                  default: ;
               endcase
            end
         end
         S_EXP_RD: state_in = S_EXP_LT;
         S_EXP_LT: begin
            mul_a = MUL_W'($signed(eval_rd_ff));
            mul_b = $signed({4'b0, time_ff});
            state_in = S_EXP_X;
         end
         S_EXP_X: begin
            mul_a = x_cl;
            mul_b = LOG2E_Q28;
            state_in = S_EXP_Y;
         end
         S_EXP_Y: begin
            n_in   = prod_ff[63:56];
            f_in   = prod_ff[55:28];
            acc_in = pow2_coef(3'd0);
            cnt_in = 6'd1;
            state_in = S_EXP_MUL;
         end
         S_EXP_MUL: begin
            mul_a = $signed({6'b0, acc_ff});
            mul_b = $signed({8'b0, f_ff});
            state_in = S_EXP_ADD;
         end
         S_EXP_ADD: begin
            acc_in = pow2_coef(cnt_ff[2:0]) + prod_ff[57:28];
            cnt_in = cnt_ff + 6'd1;
            state_in = (cnt_ff[2:0] == HORNER_LAST) ? S_EXP_SH : S_EXP_MUL;
         end
         S_EXP_SH: begin
            exp_we = 1'b1;
            if (r64 > EXP_MAX) begin
               sat_in = 1'b1;
            end
            if (j_ff == LAST) begin
               k_in = '0; base_in = '0; sum_in = '0;
               state_in = S_TRM_RD;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_EXP_RD;
            end
         end
         S_TRM_RD: state_in = S_TRM_M1;
         S_TRM_M1: begin
            mul_a = MUL_W'($signed(vec_rd0_ff));
            mul_b = MUL_W'($signed(vec_rd1_ff));
            state_in = S_TRM_M2;
         end
         S_TRM_M2: begin
            mul_a = prod_ff[63:28];
            mul_b = $signed({4'b0, exp_rd_ff});
            state_in = S_TRM_ACC;
         end
         S_TRM_ACC: begin
            sum_in = sum_ff + {{4{prod_ff[71]}}, prod_ff[71:28]};
            if (k_ff == LAST) begin
               state_in = S_FRQ_RD;
            end else begin
               k_in = k_ff + 1'b1;
               base_in = VEC_AW'(int'(base_ff) + NUM_STATES);
               state_in = S_TRM_RD;
            end
         end
         S_FRQ_RD: begin
            vec_raddr0 = VEC_AW'(to_ff);
            state_in = S_FRQ;
         end
         S_FRQ: begin
            freq_in = fq;
            neg_in  = sum_ff[47];
            if (fq == '0) begin
               if (mg == '0) begin
                  pr_in = '0;
               end else begin
                  pr_in  = sum_ff[47] ? PROB_MIN : PROB_MAX;
                  sat_in = 1'b1;
               end
               state_in = S_POST;
            end else if (mg >= {5'b0, fq, 11'b0}) begin
               pr_in  = sum_ff[47] ? PROB_MIN : PROB_MAX;
               sat_in = 1'b1;
               state_in = S_POST;
            end else begin
               r_in   = 33'(mg >> 11);
               nb_in  = {mg[10:0], 28'b0};
               q_in   = '0;
               cnt_in = DIV_STEPS;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            r_in  = ge ? (rt - {1'b0, freq_ff}) : rt;
            q_in  = {q_ff[37:0], ge};
            nb_in = nb_ff << 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               pr_in = neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (op_ff == OP_PROB) begin
               res_in.chosen_state = '0;
               res_in.probability  = pr_ff;
               res_in.fell_through = 1'b0;
               state_in = S_EMIT;
            end else begin
               run_in = run_new;
               if (s41[40] != s41[39]) begin
                  sat_in = 1'b1;
               end
               res_in.probability = '0;
               if ($signed({run_new, 4'b0}) >= $signed({12'b0, u_ff})) begin
                  res_in.chosen_state = 5'(to_ff);
                  res_in.fell_through = 1'b0;
                  state_in = S_EMIT;
               end else if (to_ff == LAST) begin
                  res_in.chosen_state = 5'(LAST);
                  res_in.fell_through = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  to_in = to_ff + 1'b1;
                  k_in = '0; base_in = '0; sum_in = '0;
                  state_in = S_TRM_RD;
               end
            end
         end
         S_EQ_RD: begin
            vec_raddr0 = VEC_AW'(j_ff);
            state_in = S_EQ;
         end
         S_EQ: begin
            cum_in = cum_new;
            res_in.probability = '0;
            if ({cum_new, 4'b0} > {10'b0, u_ff}) begin
               res_in.chosen_state = 5'(j_ff);
               res_in.fell_through = 1'b0;
               state_in = S_EMIT;
            end else if (j_ff == LAST) begin
               res_in.chosen_state = 5'(LAST);
               res_in.fell_through = 1'b1;
               state_in = S_EMIT;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_EQ_RD;
            end
         end
         S_EMIT: begin
            // output register frees when empty or being taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_data_in.saturated = sat_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; from_ff <= from_in; to_ff <= to_in; j_ff <= j_in; k_ff <= k_in;
      cnt_ff <= cnt_in; base_ff <= base_in; time_ff <= time_in; u_ff <= u_in;
      n_ff <= n_in; f_ff <= f_in; acc_ff <= acc_in; sum_ff <= sum_in;
      freq_ff <= freq_in; neg_ff <= neg_in; r_ff <= r_in;
      nb_ff <= nb_in; q_ff <= q_in; pr_ff <= pr_in; run_ff <= run_in;
      cum_ff <= cum_in; sat_ff <= sat_in; res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a fall-through always reports the last state
   a_fell_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.fell_through || rsp_data.chosen_state == 5'(LAST))
      else $error("fell_through without last state");

   // probability and sampled state never both nonzero
   a_prob_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.probability == '0 || rsp_data.chosen_state == '0)
      else $error("probability on a sampling request");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> r_ff < {1'b0, freq_ff})
      else $error("divider remainder out of range");

   // clamped exponent keeps the scale shift in range
   a_exp_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXP_SH |-> n_ff >= -8'sd47 && n_ff <= 8'sd5)
      else $error("exponent shift out of range");

endmodule
